// ===== rtl/core/scaled_alpha_sprite_blit_defines.svh =====
// Assertion macros shared by the sprite blitter RTL.
// No dependencies; included by the files that carry assertions.
`ifndef SCALED_ALPHA_SPRITE_BLIT_DEFINES_SVH
`define SCALED_ALPHA_SPRITE_BLIT_DEFINES_SVH

// same-cycle implication
`define SAB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sab: same-cycle check failed");

// next-cycle implication
`define SAB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sab: next-cycle check failed");

`endif

// ===== rtl/core/sab_pkg.sv =====
// Package for the scaled alpha sprite blitter: defaults, codes, FSM and
// controller/datapath interface types. No dependencies.
package sab_pkg;

  localparam int FB_WIDTH_DEF   = 64;
  localparam int FB_HEIGHT_DEF  = 64;
  localparam int MAX_SPRITE_DEF = 64;
  localparam int MAX_SCALE_DEF  = 8;

  localparam int PIXEL_W  = 32;
  localparam int COORD_W  = 6;
  localparam int IN_DATA_W = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int SIZE_W   = 7;
  localparam int SCALE_W  = 4;

  localparam logic [7:0] ALPHA_FULL = 8'hFF;
  localparam logic [7:0] ALPHA_NONE = 8'h00;

  typedef enum logic [1:0] {
    ACT_PIXEL = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } sab_action_t;

  typedef enum logic [2:0] {
    REG_DEST_X   = 3'd0,
    REG_DEST_Y   = 3'd1,
    REG_SCALE    = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_HEIGHT   = 3'd4,
    REG_BLEND    = 3'd5
  } sab_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GEOM,
    S_CHECK,
    S_BRD,
    S_BWR,
    S_DWR,
    S_DRD,
    S_DLOAD
  } sab_state_t;

  typedef struct packed {
    logic load;
    logic geom;
    logic check;
    logic rd;
    logic wr;
    logic drd;
    logic dwr;
    logic load_out;
  } sab_cmd_t;

  typedef struct packed {
    logic empty;
    logic ok;
    logic rmw;
    logic last;
    logic out_free;
  } sab_sts_t;

endpackage

// ===== rtl/core/sab_blend.sv =====
// Per-channel alpha blend of a source word over a destination word.
// Depends on sab_pkg.
module sab_blend
  import sab_pkg::*;
(
  input  logic [PIXEL_W-1:0] src,
  input  logic [PIXEL_W-1:0] dst,
  output logic [PIXEL_W-1:0] result
);

  always_comb begin
    logic [7:0]  a;
    logic [7:0]  inv;
    logic [15:0] prod;
    logic [16:0] q;
    a = src[7:0];
    inv = ALPHA_FULL - a;
    result = {24'd0, ALPHA_FULL};
    for (int c = 1; c < 4; c++) begin
      prod = 16'(src[c*8 +: 8]) * 16'(a) + 16'(dst[c*8 +: 8]) * 16'(inv);
      // exact divide by 255 for values up to 255*255
      q = 17'(prod) + 17'(prod[15:8]) + 17'd1;
      result[c*8 +: 8] = q[15:8];
    end
  end

endmodule

// ===== rtl/core/sab_datapath.sv =====
// Datapath: config registers, sprite counters, block geometry, frame memory,
// blend unit and output register. Depends on sab_pkg, sab_blend.
`include "scaled_alpha_sprite_blit_defines.svh"
module sab_datapath
  import sab_pkg::*;
#(
  parameter int FB_WIDTH   = FB_WIDTH_DEF,
  parameter int FB_HEIGHT  = FB_HEIGHT_DEF,
  parameter int MAX_SPRITE = MAX_SPRITE_DEF,
  parameter int MAX_SCALE  = MAX_SCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic [1:0]            in_user,
  input  sab_cmd_t              cmd,
  output sab_sts_t              sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIXEL_W-1:0]    out_data
);

  localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = ($clog2(MAX_SPRITE + 1) > SIZE_W) ? $clog2(MAX_SPRITE + 1) : SIZE_W;
  localparam int SCW   = ($clog2(MAX_SCALE + 1) > 1) ? $clog2(MAX_SCALE + 1) : 1;
  localparam int GW    = LW + 2;
  localparam int PW    = GW + SCW + 1;
  localparam int QW    = PW + 3;
  localparam logic signed [QW-1:0] FB_W_Q = QW'(FB_WIDTH);
  localparam logic signed [QW-1:0] FB_H_Q = QW'(FB_HEIGHT);

  logic signed [7:0]   dest_x;
  logic signed [7:0]   dest_y;
  logic [SCALE_W-1:0]  scale;
  logic [SIZE_W-1:0]   sprite_width;
  logic [SIZE_W-1:0]   sprite_height;
  logic                blend_mode;

  logic [LW-1:0]       col;
  logic [LW-1:0]       row;
  logic [LW-1:0]       wc;
  logic [LW-1:0]       hc;
  logic [SCW-1:0]      sc;

  logic [PIXEL_W-1:0]  word;
  logic signed [GW-1:0] lx;
  logic signed [GW-1:0] ly;
  logic signed [PW-1:0] px0;
  logic signed [PW-1:0] py0;
  logic [AW-1:0]       addr;
  logic [AW-1:0]       row_addr;
  logic [SCW-1:0]      sx;
  logic [SCW-1:0]      sy;
  logic [AW-1:0]       dir_addr;
  logic                dir_inside;

  logic [PIXEL_W-1:0]  mem [DEPTH];
  logic [PIXEL_W-1:0]  mem_q;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [PIXEL_W-1:0]  mem_wd;
  logic                mem_re;
  logic [AW-1:0]       mem_ra;
  logic [PIXEL_W-1:0]  blended;

  logic [PIXEL_W-1:0]  in_pixel;
  logic [COORD_W-1:0]  in_x;
  logic [COORD_W-1:0]  in_y;
  logic                sprite_empty;
  logic                row_end;
  logic                block_inside;
  logic signed [QW-1:0] px_end;
  logic signed [QW-1:0] py_end;

  assign in_pixel = in_data[PIXEL_W-1:0];
  assign in_x     = in_data[PIXEL_W +: COORD_W];
  assign in_y     = in_data[PIXEL_W+COORD_W +: COORD_W];

  always_comb begin
    wc = (32'(sprite_width) > MAX_SPRITE) ? LW'(MAX_SPRITE) : LW'(sprite_width);
    hc = (32'(sprite_height) > MAX_SPRITE) ? LW'(MAX_SPRITE) : LW'(sprite_height);
    if (scale == '0) begin
      sc = SCW'(1);
    end else if (32'(scale) > MAX_SCALE) begin
      sc = SCW'(MAX_SCALE);
    end else begin
      sc = SCW'(scale);
    end
    sprite_empty = (wc == '0) || (hc == '0);
    px_end = QW'(px0) + QW'(signed'({1'b0, sc}));
    py_end = QW'(py0) + QW'(signed'({1'b0, sc}));
    block_inside = (px0 >= 0) && (py0 >= 0) && (px_end <= FB_W_Q) && (py_end <= FB_H_Q);
    row_end = (sx == sc - SCW'(1));
  end

  assign sts.empty    = sprite_empty;
  assign sts.ok       = block_inside && !(blend_mode && word[7:0] == ALPHA_NONE);
  assign sts.rmw      = blend_mode && (word[7:0] != ALPHA_FULL);
  assign sts.last     = row_end && (sy == sc - SCW'(1));
  assign sts.out_free = !out_valid || out_ready;

  // config registers and sprite position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x <= '0;
      dest_y <= '0;
      scale <= SCALE_W'(1);
      sprite_width <= '0;
      sprite_height <= '0;
      blend_mode <= 1'b1;
      col <= '0;
      row <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEST_X: begin
          dest_x <= signed'(cfg_data);
          col <= '0;
          row <= '0;
        end
        REG_DEST_Y: begin
          dest_y <= signed'(cfg_data);
          col <= '0;
          row <= '0;
        end
        REG_SCALE: begin
          scale <= cfg_data[SCALE_W-1:0];
          col <= '0;
          row <= '0;
        end
        REG_WIDTH: begin
          sprite_width <= cfg_data[SIZE_W-1:0];
          col <= '0;
          row <= '0;
        end
        REG_HEIGHT: begin
          sprite_height <= cfg_data[SIZE_W-1:0];
          col <= '0;
          row <= '0;
        end
        REG_BLEND: begin
          blend_mode <= cfg_data[0];
          col <= '0;
          row <= '0;
        end
        default: ;
      endcase
    end else if (cmd.load && sab_action_t'(in_user) == ACT_PIXEL && !sprite_empty) begin
      if ((LW + 1)'(col) + (LW + 1)'(1) >= (LW + 1)'(wc)) begin
        col <= '0;
        row <= ((LW + 1)'(row) + (LW + 1)'(1) >= (LW + 1)'(hc)) ? '0 : row + LW'(1);
      end else begin
        col <= col + LW'(1);
      end
    end
  end

  // transaction capture, geometry and block walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word <= in_pixel;
      lx <= GW'(dest_x) + GW'(signed'({1'b0, col}));
      ly <= GW'(dest_y) + GW'(signed'({1'b0, row}));
      dir_inside <= (32'(in_x) < FB_WIDTH) && (32'(in_y) < FB_HEIGHT);
      dir_addr <= AW'(AW'(in_y) * AW'(FB_WIDTH)) + AW'(in_x);
    end
    if (cmd.geom) begin
      px0 <= PW'(lx) * PW'(signed'({1'b0, sc}));
      py0 <= PW'(ly) * PW'(signed'({1'b0, sc}));
    end
    if (cmd.check) begin
      row_addr <= AW'(AW'(unsigned'(py0)) * AW'(FB_WIDTH)) + AW'(unsigned'(px0));
      addr <= AW'(AW'(unsigned'(py0)) * AW'(FB_WIDTH)) + AW'(unsigned'(px0));
      sx <= '0;
      sy <= '0;
    end else if (cmd.wr) begin
      if (row_end) begin
        sx <= '0;
        sy <= sy + SCW'(1);
        row_addr <= row_addr + AW'(FB_WIDTH);
        addr <= row_addr + AW'(FB_WIDTH);
      end else begin
        sx <= sx + SCW'(1);
        addr <= addr + AW'(1);
      end
    end
  end

  sab_blend u_blend (
    .src    (word),
    .dst    (mem_q),
    .result (blended)
  );

  always_comb begin
    mem_we = cmd.wr || (cmd.dwr && dir_inside);
    mem_wa = cmd.wr ? addr : dir_addr;
    mem_wd = (cmd.wr && sts.rmw) ? blended : word;
    mem_re = cmd.rd || (cmd.drd && dir_inside);
    mem_ra = cmd.rd ? addr : dir_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= dir_inside ? mem_q : '0;
    end
  end

  `SAB_ASSERT_NXT(a_walk_starts_at_origin, clk, rst, cmd.check, sx == '0 && sy == '0)
  `SAB_ASSERT_IMP(a_one_mem_op, clk, rst, mem_we, !(cmd.rd || cmd.drd))

endmodule

// ===== rtl/core/sab_ctrl.sv =====
// Controller FSM: sequences transaction capture, block geometry,
// read-modify-write walk and direct access. Depends on sab_pkg.
`include "scaled_alpha_sprite_blit_defines.svh"
module sab_ctrl
  import sab_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [1:0] in_user,
  input  sab_sts_t sts,
  output sab_cmd_t cmd
);

  sab_state_t state;
  sab_state_t state_next;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          unique case (sab_action_t'(in_user))
            ACT_PIXEL: state_next = sts.empty ? S_IDLE : S_GEOM;
            ACT_WRITE: state_next = S_DWR;
            ACT_READ:  state_next = S_DRD;
            ACT_NOP:   state_next = S_IDLE;
          endcase
        end
      end
      S_GEOM: begin
        cmd.geom = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        priority if (!sts.ok) begin
          state_next = S_IDLE;
        end else if (sts.rmw) begin
          state_next = S_BRD;
        end else begin
          state_next = S_BWR;
        end
      end
      S_BRD: begin
        cmd.rd = 1'b1;
        state_next = S_BWR;
      end
      S_BWR: begin
        cmd.wr = 1'b1;
        priority if (sts.last) begin
          state_next = S_IDLE;
        end else if (sts.rmw) begin
          state_next = S_BRD;
        end else begin
          state_next = S_BWR;
        end
      end
      S_DWR: begin
        cmd.dwr = 1'b1;
        state_next = S_IDLE;
      end
      S_DRD: begin
        cmd.drd = 1'b1;
        state_next = S_DLOAD;
      end
      S_DLOAD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `SAB_ASSERT_IMP(a_load_needs_room, clk, rst, cmd.load_out, sts.out_free)
  `SAB_ASSERT_IMP(a_blend_after_read, clk, rst, cmd.wr && sts.rmw, $past(cmd.rd))
  `SAB_ASSERT_NXT(a_pixel_to_geom, clk, rst,
                  accept && sab_action_t'(in_user) == ACT_PIXEL && !sts.empty,
                  state == S_GEOM)

endmodule

// ===== rtl/core/scaled_alpha_sprite_blit.sv =====
// Top level of the scaled alpha sprite blitter: controller plus datapath.
// Depends on sab_pkg, sab_ctrl, sab_datapath.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  cfg      | in        | cfg_index selects register, cfg_data value
//  s_axis   | in        | tdata pixel/pixel_x/pixel_y, tuser action
//  m_axis   | out       | tdata read_pixel (direct reads only)
//
// Sprite pixel: capture, geometry and clip check, then a write per block word in copy mode
// or for alpha 255, and a read then a write per block word for partial alpha.
// Direct write: capture, then write; direct read: capture, read, then output register load.
// A read waits in its last state while the output register is still held.
// Reset clears the FSM, config and counters; frame memory is not cleared.
module scaled_alpha_sprite_blit
  import sab_pkg::*;
#(
  parameter int FB_WIDTH   = FB_WIDTH_DEF,
  parameter int FB_HEIGHT  = FB_HEIGHT_DEF,
  parameter int MAX_SPRITE = MAX_SPRITE_DEF,
  parameter int MAX_SCALE  = MAX_SCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // pixel[31:0], pixel_x, pixel_y, zero pad
  input  logic [1:0]            s_axis_tuser,  // action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [PIXEL_W-1:0]    m_axis_tdata   // read_pixel
);

  sab_cmd_t cmd;
  sab_sts_t sts;

  sab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_user  (s_axis_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  sab_datapath #(
    .FB_WIDTH   (FB_WIDTH),
    .FB_HEIGHT  (FB_HEIGHT),
    .MAX_SPRITE (MAX_SPRITE),
    .MAX_SCALE  (MAX_SCALE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ===== verif/tb_scaled_alpha_sprite_blit.sv =====
// Self-checking testbench for scaled_alpha_sprite_blit: sprite, direct write and read traffic
// checked against a framebuffer mirror kept in a small scoreboard class.
// Depends on sab_pkg and the scaled_alpha_sprite_blit RTL.
`timescale 1ns / 100ps

module tb_scaled_alpha_sprite_blit;
  import sab_pkg::*;

  localparam int SETTLE_CYCLES = 160;
  localparam int TARGET_ITEMS = 1150;
  localparam logic [2:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_IDX_SPARE_B = 3'd7;

  class frame_shadow;
    bit [31:0] fb [FB_WIDTH_DEF*FB_HEIGHT_DEF];
    bit        known [FB_WIDTH_DEF*FB_HEIGHT_DEF];
    int        filled[$];
    int        recent[$];
    bit [31:0] pending_reads[$];
    int        col, row, dx, dy;
    int        scale_reg, width_reg, height_reg;
    bit        blend_on;
    int        errors, reads_checked, drawn, dropped;

    function new();
      scale_reg = 1;
      blend_on = 1'b1;
    endfunction

    function int fit_size(int v);
      return (v > MAX_SPRITE_DEF) ? MAX_SPRITE_DEF : v;
    endfunction

    function int fit_scale();
      if (scale_reg == 0) return 1;
      return (scale_reg > MAX_SCALE_DEF) ? MAX_SCALE_DEF : scale_reg;
    endfunction

    function bit in_frame(int px0, int py0, int sc);
      return px0 >= 0 && py0 >= 0 && px0 + sc <= FB_WIDTH_DEF && py0 + sc <= FB_HEIGHT_DEF;
    endfunction

    function bit [31:0] mix(bit [31:0] s, bit [31:0] d);
      int a;
      bit [31:0] o;
      a = int'(s[7:0]);
      o = 32'h0000_00FF;
      for (int sh = 8; sh <= 24; sh += 8)
        o[sh+:8] = 8'((int'(s[sh+:8]) * a + int'(d[sh+:8]) * (255 - a)) / 255);
      return o;
    endfunction

    function void store(int idx, bit [31:0] word);
      fb[idx] = word;
      if (!known[idx]) begin
        known[idx] = 1'b1;
        filled.push_back(idx);
      end
      recent.push_back(idx);
      if (recent.size() > 64) void'(recent.pop_front());
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] v);
      case (idx)
        REG_DEST_X: dx = int'($signed(v));
        REG_DEST_Y: dy = int'($signed(v));
        REG_SCALE:  scale_reg = int'(v[3:0]);
        REG_WIDTH:  width_reg = int'(v[6:0]);
        REG_HEIGHT: height_reg = int'(v[6:0]);
        REG_BLEND:  blend_on = v[0];
        default:    return;
      endcase
      col = 0;
      row = 0;
    endfunction

    // true if a partial-alpha draw of this word would blend over an unwritten word
    function bit blend_hazard(logic [31:0] word);
      int w, h, c, r, sc, px0, py0;
      w = fit_size(width_reg);
      h = fit_size(height_reg);
      if (!blend_on || word[7:0] == ALPHA_NONE || word[7:0] == ALPHA_FULL || w == 0 || h == 0)
        return 1'b0;
      c = (col >= w) ? 0 : col;
      r = (row >= h) ? 0 : row;
      sc = fit_scale();
      px0 = (dx + c) * sc;
      py0 = (dy + r) * sc;
      if (!in_frame(px0, py0, sc)) return 1'b0;
      for (int j = 0; j < sc; j++)
        for (int i = 0; i < sc; i++)
          if (!known[(py0 + j) * FB_WIDTH_DEF + px0 + i]) return 1'b1;
      return 1'b0;
    endfunction

    // returns 1 when the transaction is counted: a pixel of a non-empty sprite, a direct write or read
    function bit apply(logic [1:0] act, logic [31:0] word, logic [5:0] x, logic [5:0] y);
      int w, h, sc, px0, py0, idx;
      case (act)
        ACT_PIXEL: begin
          w = fit_size(width_reg);
          h = fit_size(height_reg);
          if (w == 0 || h == 0) return 1'b0;
          if (col >= w) col = 0;
          if (row >= h) row = 0;
          sc = fit_scale();
          px0 = (dx + col) * sc;
          py0 = (dy + row) * sc;
          if (in_frame(px0, py0, sc) && !(blend_on && word[7:0] == ALPHA_NONE)) begin
            for (int j = 0; j < sc; j++)
              for (int i = 0; i < sc; i++) begin
                idx = (py0 + j) * FB_WIDTH_DEF + px0 + i;
                store(idx, (!blend_on || word[7:0] == ALPHA_FULL) ? word : mix(word, fb[idx]));
              end
            drawn++;
          end else begin
            dropped++;
          end
          col++;
          if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
          end
        end
        ACT_WRITE: store(int'(y) * FB_WIDTH_DEF + int'(x), word);
        ACT_READ:  pending_reads.push_back(fb[int'(y) * FB_WIDTH_DEF + int'(x)]);
        default:   return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void check_read(logic [31:0] got);
      bit [31:0] want;
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected read_pixel, expected none, got %08h", $time, got);
        errors++;
        return;
      end
      want = pending_reads.pop_front();
      reads_checked++;
      if (got !== want) begin
        $display("%0t: read_pixel mismatch, expected %08h, got %08h", $time, want, got);
        errors++;
      end
    endfunction

    function bit pick_known(output logic [5:0] x, output logic [5:0] y);
      int idx;
      if (filled.size() == 0) return 1'b0;
      if (recent.size() != 0 && $urandom_range(99) < 70)
        idx = recent[$urandom_range(recent.size() - 1)];
      else
        idx = filled[$urandom_range(filled.size() - 1)];
      x = 6'(idx % FB_WIDTH_DEF);
      y = 6'(idx / FB_WIDTH_DEF);
      return 1'b1;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // pixel[31:0], pixel_x, pixel_y, zero pad
  logic [1:0]            s_axis_tuser = '0;  // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [PIXEL_W-1:0]    m_axis_tdata;      // read_pixel

  frame_shadow shadow = new();
  bit          steady = 1'b0;
  int          counted = 0;
  int          phase = 0;

  scaled_alpha_sprite_blit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) shadow.check_read(m_axis_tdata);
    m_axis_tready <= steady || ($urandom_range(99) >= 25);
  end

  task automatic send(input logic [1:0] act, input logic [31:0] word,
                      input logic [5:0] x, input logic [5:0] y);
    if (!steady && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {4'd0, y, x, word};
    do @(posedge clk); while (!s_axis_tready);
    if (shadow.apply(act, word, x, y)) counted++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (shadow.pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.set_reg(idx, val);
  endtask

  task automatic configure(input logic [7:0] dxv, input logic [7:0] dyv, input logic [7:0] scv,
                           input logic [7:0] wv, input logic [7:0] hv, input logic [7:0] bmv);
    cfg_write(REG_DEST_X, dxv);
    cfg_write(REG_DEST_Y, dyv);
    cfg_write(REG_SCALE, scv);
    cfg_write(REG_WIDTH, wv);
    cfg_write(REG_HEIGHT, hv);
    cfg_write(REG_BLEND, bmv);
  endtask

  task automatic probe();
    logic [5:0] x, y;
    if (shadow.pick_known(x, y)) send(ACT_READ, $urandom, x, y);
  endtask

  function automatic logic [31:0] sprite_word();
    logic [31:0] word;
    int r;
    word = $urandom;
    r = $urandom_range(99);
    if (r < 25) word[7:0] = ALPHA_NONE;
    else if (r < 50) word[7:0] = ALPHA_FULL;
    if (shadow.blend_hazard(word)) word[7:0] = ALPHA_FULL;
    return word;
  endfunction

  task automatic random_frame();
    int sc, es, w, h, span, dx, dy, full, n, r;
    r = $urandom_range(99);
    if (r < 50) sc = $urandom_range(1, 2);
    else if (r < 80) sc = $urandom_range(3, 4);
    else if (r < 92) sc = $urandom_range(5, 8);
    else if (r < 96) sc = 0;
    else sc = $urandom_range(9, 15);
    es = (sc == 0) ? 1 : ((sc > MAX_SCALE_DEF) ? MAX_SCALE_DEF : sc);
    r = $urandom_range(99);
    if (r < 85) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
    end else if (r < 90) begin
      w = $urandom_range(1) ? 64 : 127;
      h = 1;
    end else if (r < 95) begin
      w = 1;
      h = $urandom_range(1) ? 64 : 127;
    end else begin
      w = $urandom_range(1) ? 0 : $urandom_range(1, 4);
      h = (w == 0) ? $urandom_range(1, 4) : 0;
    end
    span = FB_WIDTH_DEF / es;
    dx = int'($urandom_range(0, span)) - int'($urandom_range(0, 2));
    dy = int'($urandom_range(0, span)) - int'($urandom_range(0, 2));
    if ($urandom_range(99) < 6) dx = $urandom_range(1) ? -128 : 127;
    if ($urandom_range(99) < 6) dy = $urandom_range(1) ? -128 : 127;
    settle();
    configure(8'(dx), 8'(dy), {4'($urandom), 4'(sc)}, {1'($urandom), 7'(w)},
              {1'($urandom), 7'(h)}, {7'($urandom), 1'($urandom)});
    if ($urandom_range(99) < 10)
      cfg_write($urandom_range(1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B, 8'($urandom));
    full = shadow.fit_size(w) * shadow.fit_size(h);
    if (full == 0) full = 4;
    r = $urandom_range(99);
    if (r < 15) n = $urandom_range(1, full);
    else if (r < 25) n = full + $urandom_range(1, 6);
    else n = full;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 18) probe();
      else if (r < 24) send(ACT_WRITE, $urandom, 6'($urandom_range(63)), 6'($urandom_range(63)));
      else if (r < 26) send(ACT_NOP, $urandom, 6'($urandom_range(63)), 6'($urandom_range(63)));
      send(ACT_PIXEL, sprite_word(), 6'($urandom_range(63)), 6'($urandom_range(63)));
    end
    repeat ($urandom_range(1, 3)) probe();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty sprite out of reset, unused action, corner words
    send(ACT_PIXEL, 32'hDEAD_BEEF, 6'd0, 6'd0);
    send(ACT_NOP, 32'hFFFF_FFFF, 6'd63, 6'd63);
    send(ACT_WRITE, 32'hFFFF_FFFF, 6'd0, 6'd0);
    send(ACT_WRITE, 32'h0000_0000, 6'd63, 6'd63);
    send(ACT_WRITE, 32'hA5C3_0F81, 6'd63, 6'd0);
    send(ACT_READ, 32'h0000_0000, 6'd0, 6'd0);
    send(ACT_READ, 32'hFFFF_FFFF, 6'd63, 6'd63);
    send(ACT_READ, 32'h0000_0000, 6'd63, 6'd0);
    settle();

    // copy mode, scale zero behaves as one
    configure(8'd0, 8'd0, 8'd0, 8'd2, 8'd1, 8'd0);
    send(ACT_PIXEL, 32'h1122_3300, 6'd0, 6'd0);
    send(ACT_PIXEL, 32'h4455_66FF, 6'd0, 6'd0);
    send(ACT_READ, 32'h0000_0000, 6'd0, 6'd0);
    send(ACT_READ, 32'h0000_0000, 6'd1, 6'd0);
    settle();

    // oversized scale saturates; block flush with the bottom-right corner
    configure(8'd7, 8'd7, 8'd15, 8'd1, 8'd1, 8'd1);
    send(ACT_PIXEL, 32'h8080_8000, 6'd0, 6'd0);
    send(ACT_PIXEL, 32'hFF00_00FF, 6'd0, 6'd0);
    send(ACT_PIXEL, 32'h00FF_8080, 6'd0, 6'd0);
    send(ACT_READ, 32'h0000_0000, 6'd56, 6'd56);
    send(ACT_READ, 32'h0000_0000, 6'd63, 6'd63);
    settle();

    // destination far outside on both axes
    configure(8'h80, 8'h7F, 8'd1, 8'd1, 8'd1, 8'd0);
    send(ACT_PIXEL, 32'h1234_5678, 6'd0, 6'd0);
    send(ACT_READ, 32'h0000_0000, 6'd63, 6'd63);
    settle();

    // writes to spare indexes keep the position counters
    configure(8'd10, 8'd0, 8'd1, 8'd2, 8'd1, 8'd0);
    send(ACT_PIXEL, 32'hCAFE_0001, 6'd0, 6'd0);
    settle();
    cfg_write(CFG_IDX_SPARE_A, 8'hFF);
    cfg_write(CFG_IDX_SPARE_B, 8'h00);
    send(ACT_PIXEL, 32'hCAFE_0002, 6'd0, 6'd0);
    send(ACT_READ, 32'h0000_0000, 6'd10, 6'd0);
    send(ACT_READ, 32'h0000_0000, 6'd11, 6'd0);

    while (counted < TARGET_ITEMS) begin
      steady = (phase >= 6 && phase < 14);
      random_frame();
      phase++;
    end
    steady = 1'b0;
    settle();

    $display("Covered %0d transactions in %0d random frames: %0d reads checked,",
             counted, phase, shadow.reads_checked);
    $display("%0d sprite pixels drawn and %0d clipped or transparent.",
             shadow.drawn, shadow.dropped);
    if (shadow.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
